/* src/aes_ctr_pkg.sv */
// Package for the AES-128 counter mode block: payload types, round constants,
// the S-box table and the xtime function. No dependencies.
package aes_ctr_pkg;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  valid_bytes;
    logic        is_iv;
  } out_item_t;

  localparam logic [1:0] CFG_KEY_HIGH  = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW   = 2'd1;
  localparam logic [1:0] CFG_DIRECTION = 2'd2;

  localparam logic        KIND_IV    = 1'b0;
  localparam logic        KIND_DATA  = 1'b1;
  localparam logic [4:0]  BLOCK_BYTES = 5'd16;

  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

/* src/aes128_ctr_stream.sv */
// Top level of the AES-128 counter mode block: config registers, on-the-fly
// key schedule, one shared round unit and the output register. Uses aes_ctr_pkg.
//
// Usage:
//   cfg channel: index 0 key bytes 0..7, 1 key bytes 8..15, 2 direction.
//     Write only while the block is idle. Other indexes are dropped.
//   in channel: kind 0 loads the IV into the counter (echoed as an is_iv
//     item in encrypt direction, silent in decrypt). kind 1 is a data block
//     XORed with AES(counter); bytes at or past byte_count come out zero,
//     byte_count 0 gives no item, counts above 16 count as 16.
//   out channel: one registered item, held until taken.
// Flow: an IV item is handled as it is accepted. A data block gets its initial
//   key add on acceptance, runs ten rounds in the round unit (one per cycle,
//   round keys computed alongside from the cipher key) and lands in od_r.
//   in_ready is low while a block is in the round unit or while the output
//   register is full and not being taken, so a stalled receiver stalls input.
// Reset: counter, key and direction clear to zero; no clearing pass is needed
//   since round keys are derived from the key registers for every block.
module aes128_ctr_stream (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aes_ctr_pkg::in_item_t  in_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output aes_ctr_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_wdata
);
  import aes_ctr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic         state_r, state_nxt;
  logic [3:0]   round_r, round_nxt;
  logic [127:0] key_r, key_nxt;
  logic         dir_r, dir_nxt;
  logic [127:0] ctr_r, ctr_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [127:0] din_r, din_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         ov_r, ov_nxt;
  out_item_t    od_r, od_nxt;

  logic         in_fire, out_free;
  logic [4:0]   cnt_sat;
  logic [127:0] sr, mc, rnd, rk_next_key, ks, masked;
  logic [31:0]  w3, tw;

  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign cnt_sat   = (in_data.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : in_data.byte_count;

  // Shared round unit: SubBytes and ShiftRows, then MixColumns.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8*(r + 4*c) -: 8] = SBOX[st_r[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[127 - 32*c -: 8];
      a1 = sr[119 - 32*c -: 8];
      a2 = sr[111 - 32*c -: 8];
      a3 = sr[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
  end

  // Next round key from the current one; round_r is the round about to run.
  always_comb begin
    w3 = rk_r[31:0];
    tw = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
         ^ {RCON[round_r - 4'd1], 24'h0};
    rk_next_key[127:96] = rk_r[127:96] ^ tw;
    rk_next_key[95:64]  = rk_r[95:64] ^ rk_next_key[127:96];
    rk_next_key[63:32]  = rk_r[63:32] ^ rk_next_key[95:64];
    rk_next_key[31:0]   = rk_r[31:0] ^ rk_next_key[63:32];
  end

  assign rnd = ((round_r == 4'd10) ? sr : mc) ^ rk_next_key;
  assign ks  = rnd ^ din_r;

  // Keep only the leading valid bytes.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      masked[127 - 8*i -: 8] = (5'(i) < cnt_r) ? ks[127 - 8*i -: 8] : 8'h00;
    end
  end

  // Config writes, sequencer, counter and output register.
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    key_nxt   = key_r;
    dir_nxt   = dir_r;
    ctr_nxt   = ctr_r;
    st_nxt    = st_r;
    rk_nxt    = rk_r;
    din_nxt   = din_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_HIGH:  key_nxt[127:64] = cfg_wdata;
        CFG_KEY_LOW:   key_nxt[63:0]   = cfg_wdata;
        CFG_DIRECTION: dir_nxt         = cfg_wdata[0];
        default: ;
      endcase
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_IV) begin
            ctr_nxt = {in_data.data_high, in_data.data_low};
            if (!dir_r) begin
              ov_nxt = 1'b1;
              od_nxt = '{out_high: in_data.data_high, out_low: in_data.data_low,
                         valid_bytes: BLOCK_BYTES, is_iv: 1'b1};
            end
          end else if (in_data.byte_count != 5'd0) begin
            // Initial key addition, then ten rounds.
            st_nxt    = ctr_r ^ key_r;
            rk_nxt    = key_r;
            din_nxt   = {in_data.data_high, in_data.data_low};
            cnt_nxt   = cnt_sat;
            round_nxt = 4'd1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        st_nxt    = rnd;
        rk_nxt    = rk_next_key;
        round_nxt = round_r + 4'd1;
        if (round_r == 4'd10) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{out_high: masked[127:64], out_low: masked[63:0],
                        valid_bytes: cnt_r, is_iv: 1'b0};
          ctr_nxt   = ctr_r + 128'd1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= 4'd0;
      key_r   <= '0;
      dir_r   <= 1'b0;
      ctr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      key_r   <= key_nxt;
      dir_r   <= dir_nxt;
      ctr_r   <= ctr_nxt;
      ov_r    <= ov_nxt;
    end
    st_r  <= st_nxt;
    rk_r  <= rk_nxt;
    din_r <= din_nxt;
    cnt_r <= cnt_nxt;
    od_r  <= od_nxt;
  end

endmodule
